FILE: rtl/three_lane_budget_drain_arbiter_assert.svh
// assertion macros for the three lane budget drain arbiter checker
// depends on nothing; clock clk and reset rst_n must be in scope at the use site
`ifndef THREE_LANE_BUDGET_DRAIN_ARBITER_ASSERT_SVH
`define THREE_LANE_BUDGET_DRAIN_ARBITER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TLBDA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, disabled in reset
`define TLBDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: rtl/tlbda_pkg.sv
// shared types and constants for the three lane budget drain arbiter
// no dependencies
`timescale 1ns / 1ps

package tlbda_pkg;

    // fixed field widths of the item ports
    localparam int IN_W   = 7;
    localparam int LANE_W = 2;

    // quota floors
    localparam int CQ_MIN = 4;
    localparam int NQ_MIN = 2;
    localparam int BQ_MIN = 1;

    // lane codes
    typedef enum logic [LANE_W-1:0] {
        LANE_CONTROL = 2'd0,
        LANE_NORMAL  = 2'd1,
        LANE_BULK    = 2'd2
    } lane_t;

    // sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SETUP,
        SEQ_GRANT,
        SEQ_EMPTY
    } seq_state_t;

    // one result offered by the grant engine to the output register
    typedef struct packed {
        logic  valid;
        lane_t lane;
        logic  granted;
        logic  last;
    } emit_t;

endpackage

FILE: rtl/tlbda_quota.sv
// quota and total-grant calculation from the latched budget and lane counts
// depends on tlbda_pkg
`timescale 1ns / 1ps

module tlbda_quota #(
    parameter int MAX_BUDGET = 64,
    parameter int LANE_DEPTH = 64
) (
    input  logic [$clog2(MAX_BUDGET+1)-1:0]                                 b,
    input  logic [$clog2(LANE_DEPTH+1)-1:0]                                 cw,
    input  logic [$clog2(LANE_DEPTH+1)-1:0]                                 nw,
    input  logic [$clog2(LANE_DEPTH+1)-1:0]                                 bw,
    input  logic                                                            unused_tie,
    output logic [(($clog2(MAX_BUDGET+1) > 3) ? $clog2(MAX_BUDGET+1) : 3)-1:0] cq,
    output logic [(($clog2(MAX_BUDGET+1) > 3) ? $clog2(MAX_BUDGET+1) : 3)-1:0] nq,
    output logic [(($clog2(MAX_BUDGET+1) > 3) ? $clog2(MAX_BUDGET+1) : 3)-1:0] bq,
    output logic [$clog2(MAX_BUDGET+1)-1:0]                                 total
);

    localparam int BW = $clog2(MAX_BUDGET + 1);
    localparam int WW = $clog2(LANE_DEPTH + 1);
    localparam int QW = (BW > 3) ? BW : 3;
    localparam int SW = ((WW + 2) > BW) ? (WW + 2) : BW;

    logic [QW-1:0]   b_q;
    logic [QW+2:0]   five_b;
    logic [QW+1:0]   three_b;
    logic [QW-1:0]   cq_raw;
    logic [QW-1:0]   nq_raw;
    logic [QW:0]     cq_nq;
    logic [QW-1:0]   bq_diff;
    logic [SW-1:0]   lane_sum;
    logic [SW-1:0]   b_wide;

    // five eighths and three eighths of the budget by shift and add
    always_comb
    begin
        b_q     = QW'(b);
        five_b  = ({3'b000, b_q} << 2) + {3'b000, b_q};
        three_b = ({2'b00, b_q} << 1) + {2'b00, b_q};
        cq_raw  = QW'(five_b >> 3);
        nq_raw  = QW'(three_b >> 3);
    end

    // floors on the control and normal quotas
    assign cq = (cq_raw < QW'(tlbda_pkg::CQ_MIN)) ? QW'(tlbda_pkg::CQ_MIN) : cq_raw;
    assign nq = (nq_raw < QW'(tlbda_pkg::NQ_MIN)) ? QW'(tlbda_pkg::NQ_MIN) : nq_raw;

    // bulk gets the remainder floored at BQ_MIN, or the budget when it is negative
    always_comb
    begin
        cq_nq   = {1'b0, cq} + {1'b0, nq};
        bq_diff = QW'({1'b0, b_q} - cq_nq);
        if ({1'b0, b_q} >= cq_nq)
        begin
            bq = (bq_diff < QW'(tlbda_pkg::BQ_MIN)) ? QW'(tlbda_pkg::BQ_MIN) : bq_diff;
        end
        else
        begin
            bq = b_q;
        end
    end

    // grants in all equal min(budget, messages waiting)
    always_comb
    begin
        lane_sum = SW'(cw) + SW'(nw) + SW'(bw);
        b_wide   = SW'(b);
        total    = (lane_sum > b_wide) ? b : BW'(lane_sum | {SW{unused_tie}});
    end

endmodule

FILE: rtl/tlbda_engine.sv
// grant sequencer: walks the lanes one grant per cycle while the output is
// free, through one shared decrement path; depends on tlbda_pkg and tlbda_quota
`timescale 1ns / 1ps

module tlbda_engine #(
    parameter int MAX_BUDGET = 64,
    parameter int LANE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [$clog2(MAX_BUDGET+1)-1:0]  b_in,
    input  logic [$clog2(LANE_DEPTH+1)-1:0]  cw_in,
    input  logic [$clog2(LANE_DEPTH+1)-1:0]  nw_in,
    input  logic [$clog2(LANE_DEPTH+1)-1:0]  bw_in,
    input  logic                             out_free,
    output logic                             busy,
    output tlbda_pkg::emit_t                 emit
);

    localparam int BW = $clog2(MAX_BUDGET + 1);
    localparam int WW = $clog2(LANE_DEPTH + 1);
    localparam int QW = (BW > 3) ? BW : 3;

    tlbda_pkg::seq_state_t state_reg, state_next;
    tlbda_pkg::lane_t      lane_reg, lane_next;
    logic                  spill_reg, spill_next;
    logic [QW-1:0]         cap_reg, cap_next;
    logic [BW-1:0]         rem_reg, rem_next;
    logic [BW-1:0]         b_reg, b_next;
    logic [WW-1:0]         cw_reg, cw_next;
    logic [WW-1:0]         nw_reg, nw_next;
    logic [WW-1:0]         bw_reg, bw_next;
    logic [QW-1:0]         nq_reg, nq_next;
    logic [QW-1:0]         bq_reg, bq_next;

    logic [QW-1:0]         cq_c, nq_c, bq_c;
    logic [BW-1:0]         total_c;
    logic [WW-1:0]         wsel;
    logic [WW-1:0]         wsel_dec;
    logic                  can_grant;

    // quotas and grant total from the latched request
    tlbda_quota #(
        .MAX_BUDGET (MAX_BUDGET),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_quota (
        .b          (b_reg),
        .cw         (cw_reg),
        .nw         (nw_reg),
        .bw         (bw_reg),
        .unused_tie (1'b0),
        .cq         (cq_c),
        .nq         (nq_c),
        .bq         (bq_c),
        .total      (total_c)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbda_pkg::SEQ_IDLE;
            lane_reg  <= tlbda_pkg::LANE_CONTROL;
            spill_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            spill_reg <= spill_next;
        end
    end

    // counters and latched request
    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
        cw_reg  <= cw_next;
        nw_reg  <= nw_next;
        bw_reg  <= bw_next;
        nq_reg  <= nq_next;
        bq_reg  <= bq_next;
    end

    // selected lane count and its shared decrement
    always_comb
    begin
        case (lane_reg)
            tlbda_pkg::LANE_CONTROL: wsel = cw_reg;
            tlbda_pkg::LANE_NORMAL:  wsel = nw_reg;
            tlbda_pkg::LANE_BULK:    wsel = bw_reg;
            default:                 wsel = '0;
        endcase
        wsel_dec  = wsel - WW'(1);
        can_grant = (spill_reg || (cap_reg != '0)) && (wsel != '0) && (rem_reg != '0);
    end

    // next state and offered result
    always_comb
    begin
        state_next   = state_reg;
        lane_next    = lane_reg;
        spill_next   = spill_reg;
        cap_next     = cap_reg;
        rem_next     = rem_reg;
        b_next       = b_reg;
        cw_next      = cw_reg;
        nw_next      = nw_reg;
        bw_next      = bw_reg;
        nq_next      = nq_reg;
        bq_next      = bq_reg;
        emit.valid   = 1'b0;
        emit.lane    = lane_reg;
        emit.granted = 1'b1;
        emit.last    = (rem_reg == BW'(1));

        case (state_reg)
            tlbda_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    b_next     = b_in;
                    cw_next    = cw_in;
                    nw_next    = nw_in;
                    bw_next    = bw_in;
                    state_next = tlbda_pkg::SEQ_SETUP;
                end
            end
            tlbda_pkg::SEQ_SETUP:
            begin
                cap_next   = cq_c;
                nq_next    = nq_c;
                bq_next    = bq_c;
                rem_next   = total_c;
                lane_next  = tlbda_pkg::LANE_CONTROL;
                spill_next = 1'b0;
                state_next = (total_c == '0) ? tlbda_pkg::SEQ_EMPTY : tlbda_pkg::SEQ_GRANT;
            end
            tlbda_pkg::SEQ_GRANT:
            begin
                if (can_grant)
                begin
                    // one grant from the current lane
                    if (out_free)
                    begin
                        emit.valid = 1'b1;
                        rem_next   = rem_reg - BW'(1);
                        cap_next   = cap_reg - QW'(1);
                        case (lane_reg)
                            tlbda_pkg::LANE_CONTROL: cw_next = wsel_dec;
                            tlbda_pkg::LANE_NORMAL:  nw_next = wsel_dec;
                            tlbda_pkg::LANE_BULK:    bw_next = wsel_dec;
                            default:                 cw_next = cw_reg;
                        endcase
                        if (rem_reg == BW'(1))
                        begin
                            state_next = tlbda_pkg::SEQ_IDLE;
                        end
                    end
                end
                else
                begin
                    // move on to the next lane, wrapping into the leftover pass
                    case (lane_reg)
                        tlbda_pkg::LANE_CONTROL:
                        begin
                            lane_next = tlbda_pkg::LANE_NORMAL;
                            cap_next  = nq_reg;
                        end
                        tlbda_pkg::LANE_NORMAL:
                        begin
                            lane_next = tlbda_pkg::LANE_BULK;
                            cap_next  = bq_reg;
                        end
                        default:
                        begin
                            lane_next  = tlbda_pkg::LANE_CONTROL;
                            spill_next = 1'b1;
                        end
                    endcase
                    // nothing left to grant anywhere
                    if (rem_reg == '0)
                    begin
                        state_next = tlbda_pkg::SEQ_IDLE;
                    end
                end
            end
            tlbda_pkg::SEQ_EMPTY:
            begin
                emit.lane    = tlbda_pkg::LANE_CONTROL;
                emit.granted = 1'b0;
                emit.last    = 1'b1;
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    state_next = tlbda_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = tlbda_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != tlbda_pkg::SEQ_IDLE);

endmodule

FILE: rtl/three_lane_budget_drain_arbiter.sv
// top level of the three lane budget drain arbiter: input saturation,
// grant engine and output register; depends on tlbda_pkg and tlbda_engine
//
//   channel   signals                                             dir   handshake
//   request   budget control_waiting normal_waiting bulk_waiting  in    in_valid / in_stall
//   result    lane granted last                                   out   out_valid / out_stall
//
// after the accept a request goes through a setup state and then the grant
// state, which passes over each lane that cannot grant and returns to idle
// after the last grant; the grant sequencer emits at most one result per cycle
// a request that grants nothing gives one empty result
// in_stall is high from the accept until the last result enters the output
// register; out_stall holds the output register and pauses the sequencer
// rst_n clears the sequencer and the output valid flag asynchronously
`timescale 1ns / 1ps

module three_lane_budget_drain_arbiter #(
    parameter int MAX_BUDGET = 64,
    parameter int LANE_DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tlbda_pkg::IN_W-1:0]   budget,
    input  logic [tlbda_pkg::IN_W-1:0]   control_waiting,
    input  logic [tlbda_pkg::IN_W-1:0]   normal_waiting,
    input  logic [tlbda_pkg::IN_W-1:0]   bulk_waiting,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tlbda_pkg::LANE_W-1:0] lane,
    output logic                         granted,
    output logic                         last
);

    localparam int BW = $clog2(MAX_BUDGET + 1);
    localparam int WW = $clog2(LANE_DEPTH + 1);

    logic             in_accept;
    logic             busy;
    logic             out_free;
    logic [BW-1:0]    b_sat;
    logic [WW-1:0]    cw_sat;
    logic [WW-1:0]    nw_sat;
    logic [WW-1:0]    bw_sat;
    tlbda_pkg::emit_t emit;

    logic                         out_valid_reg, out_valid_next;
    logic [tlbda_pkg::LANE_W-1:0] lane_reg, lane_next;
    logic                         granted_reg, granted_next;
    logic                         last_reg, last_next;

    // clamp each field to its range
    always_comb
    begin
        b_sat  = (budget > tlbda_pkg::IN_W'(MAX_BUDGET)) ? BW'(MAX_BUDGET) : budget[BW-1:0];
        cw_sat = (control_waiting > tlbda_pkg::IN_W'(LANE_DEPTH)) ?
                 WW'(LANE_DEPTH) : control_waiting[WW-1:0];
        nw_sat = (normal_waiting > tlbda_pkg::IN_W'(LANE_DEPTH)) ?
                 WW'(LANE_DEPTH) : normal_waiting[WW-1:0];
        bw_sat = (bulk_waiting > tlbda_pkg::IN_W'(LANE_DEPTH)) ?
                 WW'(LANE_DEPTH) : bulk_waiting[WW-1:0];
    end

    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;
    assign out_free  = !out_valid_reg || !out_stall;

    // grant sequencer
    tlbda_engine #(
        .MAX_BUDGET (MAX_BUDGET),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .b_in     (b_sat),
        .cw_in    (cw_sat),
        .nw_in    (nw_sat),
        .bw_in    (bw_sat),
        .out_free (out_free),
        .busy     (busy),
        .emit     (emit)
    );

    // output register load and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        lane_next      = lane_reg;
        granted_next   = granted_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = emit.valid;
            if (emit.valid)
            begin
                lane_next    = emit.lane;
                granted_next = emit.granted;
                last_next    = emit.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg    <= lane_next;
        granted_reg <= granted_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign lane      = lane_reg;
    assign granted   = granted_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/tlbda_checker.sv
// port-level checks for the three lane budget drain arbiter, bound to the top
// depends on tlbda_pkg and three_lane_budget_drain_arbiter_assert.svh
`timescale 1ns / 1ps
`include "three_lane_budget_drain_arbiter_assert.svh"

module tlbda_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [tlbda_pkg::LANE_W-1:0] lane,
    input logic                         granted,
    input logic                         last
);

    // an empty result always closes its request
    `TLBDA_ASSERT_IMPLY(a_empty_is_last, out_valid && !granted, last)

    // an empty result reports the control lane
    `TLBDA_ASSERT_IMPLY(a_empty_lane, out_valid && !granted, lane == tlbda_pkg::LANE_CONTROL)

    // an accepted request keeps the input side stalled while it sets up
    `TLBDA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a stalled result stays in place
    `TLBDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                       out_valid && $stable(lane) && $stable(granted) && $stable(last))

endmodule

bind three_lane_budget_drain_arbiter tlbda_checker u_tlbda_checker (.*);

FILE: test/tb_three_lane_budget_drain_arbiter.sv
// testbench for three_lane_budget_drain_arbiter: directed and random requests
// with an in-bench grant planner and an in-order scoreboard of expected grants
// depends on tlbda_pkg and the three_lane_budget_drain_arbiter rtl
`timescale 1ns / 1ps

module tb_three_lane_budget_drain_arbiter;

    localparam int MAX_BUDGET = 64;
    localparam int LANE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_AT_ITEM = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 20;

    // one drain request waiting to be sent
    typedef struct {
        logic [tlbda_pkg::IN_W-1:0] budget;
        logic [tlbda_pkg::IN_W-1:0] control_waiting;
        logic [tlbda_pkg::IN_W-1:0] normal_waiting;
        logic [tlbda_pkg::IN_W-1:0] bulk_waiting;
        bit                         drain_first;
    } drain_req_t;

    // one expected grant result
    typedef struct {
        tlbda_pkg::lane_t lane;
        logic             granted;
        logic             last;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [tlbda_pkg::IN_W-1:0] budget = '0;
    logic [tlbda_pkg::IN_W-1:0] control_waiting = '0;
    logic [tlbda_pkg::IN_W-1:0] normal_waiting = '0;
    logic [tlbda_pkg::IN_W-1:0] bulk_waiting = '0;
    logic out_valid;
    logic out_stall;
    logic [tlbda_pkg::LANE_W-1:0] lane;
    logic granted;
    logic last;

    logic rx_stall = 1'b0;
    logic hold_off = 1'b0;

    drain_req_t request_q[$];
    grant_t     grant_q[$];
    int         fault_count = 0;
    int         items_taken = 0;
    int         tx_gap = 0;
    int         tx_calm = 0;
    int         rx_left = 0;
    int         rx_calm = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    assign out_stall = rx_stall | hold_off;

    three_lane_budget_drain_arbiter #(
        .MAX_BUDGET(MAX_BUDGET),
        .LANE_DEPTH(LANE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .budget(budget),
        .control_waiting(control_waiting),
        .normal_waiting(normal_waiting),
        .bulk_waiting(bulk_waiting),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .lane(lane),
        .granted(granted),
        .last(last)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // gap length: mostly none or short, a few long, with calm stretches
    function automatic int draw_pause(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // lane occupancy: empty, small, in range, or above the lane depth
    function automatic logic [tlbda_pkg::IN_W-1:0] pick_waiting();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        if (r < 30)
            return tlbda_pkg::IN_W'($urandom_range(LANE_DEPTH + 1, 127));
        if (r < 50)
            return tlbda_pkg::IN_W'($urandom_range(1, 8));
        return tlbda_pkg::IN_W'($urandom_range(0, LANE_DEPTH));
    endfunction

    // budget: zero, small, full range, or above the maximum
    function automatic logic [tlbda_pkg::IN_W-1:0] pick_budget();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 12)
            return tlbda_pkg::IN_W'($urandom_range(MAX_BUDGET + 1, 127));
        if (r < 35)
            return tlbda_pkg::IN_W'($urandom_range(1, 12));
        return tlbda_pkg::IN_W'($urandom_range(0, MAX_BUDGET));
    endfunction

    task automatic add_request(input int b, input int c, input int n, input int k,
                               input bit drain);
        drain_req_t req;
        req.budget = tlbda_pkg::IN_W'(b);
        req.control_waiting = tlbda_pkg::IN_W'(c);
        req.normal_waiting = tlbda_pkg::IN_W'(n);
        req.bulk_waiting = tlbda_pkg::IN_W'(k);
        req.drain_first = drain;
        request_q.push_back(req);
    endtask

    // work out the grants of one drain request and queue them in order
    task automatic plan_drain(input logic [tlbda_pkg::IN_W-1:0] b_raw,
                              input logic [tlbda_pkg::IN_W-1:0] c_raw,
                              input logic [tlbda_pkg::IN_W-1:0] n_raw,
                              input logic [tlbda_pkg::IN_W-1:0] k_raw);
        int    b;
        int    cq;
        int    nq;
        int    bq;
        int    left;
        int    cnt;
        int    g;
        int    idx;
        int    pending_n[3];
        int    caps[6];
        tlbda_pkg::lane_t order[6];
        grant_t gr;
        b = (b_raw > MAX_BUDGET) ? MAX_BUDGET : int'(b_raw);
        pending_n[0] = (c_raw > LANE_DEPTH) ? LANE_DEPTH : int'(c_raw);
        pending_n[1] = (n_raw > LANE_DEPTH) ? LANE_DEPTH : int'(n_raw);
        pending_n[2] = (k_raw > LANE_DEPTH) ? LANE_DEPTH : int'(k_raw);

        // quotas with their floors; bulk is capped only by budget when short
        cq = (b * 5) / 8;
        if (cq < tlbda_pkg::CQ_MIN)
            cq = tlbda_pkg::CQ_MIN;
        nq = (b * 3) / 8;
        if (nq < tlbda_pkg::NQ_MIN)
            nq = tlbda_pkg::NQ_MIN;
        if (b >= cq + nq)
        begin
            bq = b - cq - nq;
            if (bq < tlbda_pkg::BQ_MIN)
                bq = tlbda_pkg::BQ_MIN;
        end
        else
            bq = b;

        // quota passes, then leftover budget by strict priority
        order = '{tlbda_pkg::LANE_CONTROL, tlbda_pkg::LANE_NORMAL, tlbda_pkg::LANE_BULK,
                  tlbda_pkg::LANE_CONTROL, tlbda_pkg::LANE_NORMAL, tlbda_pkg::LANE_BULK};
        caps = '{cq, nq, bq, MAX_BUDGET, MAX_BUDGET, MAX_BUDGET};
        left = b;
        cnt = 0;
        for (int p = 0; p < 6; p++)
        begin
            idx = p % 3;
            g = caps[p];
            if (pending_n[idx] < g)
                g = pending_n[idx];
            if (left < g)
                g = left;
            for (int i = 0; i < g; i++)
            begin
                gr.lane = order[p];
                gr.granted = 1'b1;
                gr.last = 1'b0;
                grant_q.push_back(gr);
            end
            pending_n[idx] -= g;
            left -= g;
            cnt += g;
        end

        // nothing granted gives one empty closing result
        if (cnt == 0)
        begin
            gr.lane = tlbda_pkg::LANE_CONTROL;
            gr.granted = 1'b0;
            gr.last = 1'b1;
            grant_q.push_back(gr);
        end
        else
            grant_q[grant_q.size() - 1].last = 1'b1;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        int tx_wait;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            budget <= '0;
            control_waiting <= '0;
            normal_waiting <= '0;
            bulk_waiting <= '0;
            tx_gap <= 0;
        end
        else
        begin
            tx_wait = tx_gap;
            if (in_valid && !in_stall)
            begin
                plan_drain(budget, control_waiting, normal_waiting, bulk_waiting);
                items_taken <= items_taken + 1;
                tx_wait = draw_pause(tx_calm);
            end

            if (in_valid && in_stall)
            begin
                // hold the offered item
            end
            else if (tx_wait > 0)
            begin
                in_valid <= 1'b0;
                tx_gap <= tx_wait - 1;
            end
            else if (request_q.size() > 0 &&
                     !(request_q[0].drain_first && grant_q.size() != 0))
            begin
                in_valid <= 1'b1;
                budget <= request_q[0].budget;
                control_waiting <= request_q[0].control_waiting;
                normal_waiting <= request_q[0].normal_waiting;
                bulk_waiting <= request_q[0].bulk_waiting;
                void'(request_q.pop_front());
                tx_gap <= 0;
            end
            else
            begin
                in_valid <= 1'b0;
                tx_gap <= 0;
            end
        end
    end

    // result monitor and random receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : grant_monitor
        grant_t exp_gr;
        int     pause;
        if (!rst_n)
        begin
            rx_stall <= 1'b0;
            rx_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (grant_q.size() == 0)
                begin
                    $error("unexpected result: lane %0d granted %0d last %0d",
                           lane, granted, last);
                    fault_count++;
                end
                else
                begin
                    exp_gr = grant_q.pop_front();
                    if (lane !== exp_gr.lane)
                    begin
                        $error("lane: expected %0d, actual %0d", exp_gr.lane, lane);
                        fault_count++;
                    end
                    if (granted !== exp_gr.granted)
                    begin
                        $error("granted: expected %0d, actual %0d", exp_gr.granted, granted);
                        fault_count++;
                    end
                    if (last !== exp_gr.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_gr.last, last);
                        fault_count++;
                    end
                end
            end

            if (rx_left > 0)
            begin
                rx_stall <= 1'b1;
                rx_left <= rx_left - 1;
            end
            else
            begin
                pause = draw_pause(rx_calm);
                rx_stall <= (pause > 0);
                rx_left <= (pause > 0) ? pause - 1 : 0;
            end
        end
    end

    // one long receiver hold-off while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_off)
        begin
            if (hold_left == 0)
                hold_off <= 1'b0;
            else
                hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_taken >= HOLD_AT_ITEM)
        begin
            hold_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // directed: empty cases, saturation, quota edges, leftover priority
        add_request(0, 64, 64, 64, 1'b0);
        add_request(64, 0, 0, 0, 1'b0);
        add_request(0, 0, 0, 0, 1'b0);
        add_request(64, 64, 64, 64, 1'b0);
        add_request(127, 127, 127, 127, 1'b0);
        add_request(100, 65, 70, 90, 1'b0);
        add_request(1, 5, 5, 5, 1'b0);
        add_request(1, 0, 0, 5, 1'b0);
        add_request(5, 5, 5, 5, 1'b0);
        add_request(5, 0, 0, 9, 1'b0);
        add_request(6, 9, 9, 9, 1'b0);
        add_request(16, 20, 20, 20, 1'b0);
        add_request(63, 64, 64, 64, 1'b0);
        add_request(64, 64, 0, 0, 1'b0);
        add_request(64, 0, 64, 0, 1'b0);
        add_request(64, 0, 0, 64, 1'b0);
        add_request(10, 1, 1, 64, 1'b0);
        add_request(20, 2, 64, 1, 1'b0);
        add_request(42, 63, 1, 2, 1'b0);
        add_request(21, 85, 42, 21, 1'b0);
        add_request(3, 1, 0, 0, 1'b1);

        // random requests, a few of them sent only once everything drained
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_request(pick_budget(), pick_waiting(), pick_waiting(), pick_waiting(),
                        ($urandom_range(0, 99) < 5));

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (request_q.size() != 0 || in_valid || grant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tlbda_pkg.sv
rtl/tlbda_quota.sv
rtl/tlbda_engine.sv
rtl/three_lane_budget_drain_arbiter.sv
rtl/tlbda_checker.sv
test/tb_three_lane_budget_drain_arbiter.sv
